// ----- rtl/rsld_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, payload types and the sign generator for the ring sheaf diffusion core.
package rsld_pkg;

  localparam int unsigned NodesDefault = 16;
  localparam int unsigned DimDefault   = 8;

  localparam logic [63:0] DefaultSeed = 64'h95C0FAA595C0FAA5;

  localparam logic [1:0] ModeInit = 2'd0;
  localparam logic [1:0] ModeLoad = 2'd1;
  localparam logic [1:0] ModeStep = 2'd2;
  localparam logic [1:0] ModeRead = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         node;
    logic [2:0]         dim;
    logic signed [31:0] value;
    logic               last;
  } rsld_req_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [62:0]        energy;
    logic [31:0]        violations;
    logic [31:0]        steps;
    logic               ok;
  } rsld_rsp_t;

  typedef struct packed {
    logic sig_we;
    logic lap_we;
    logic sgn_we;
  } rsld_wen_t;

  function automatic logic [63:0] xorshift(input logic [63:0] r);
    logic [63:0] x;
    x = r ^ (r << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

endpackage

// ----- rtl/rsld_store.sv -----
`timescale 1ns / 1ps
// Signal, Laplacian scratch and edge sign memories, one write and one registered read each.
module rsld_store #(
  parameter int unsigned NODES = rsld_pkg::NodesDefault,
  parameter int unsigned DIM   = rsld_pkg::DimDefault,
  localparam int unsigned CELLS  = NODES * DIM,
  localparam int unsigned CELL_W = $clog2(CELLS)
) (
  input  logic                clk_i,
  input  rsld_pkg::rsld_wen_t wen_i,
  input  logic [CELL_W-1:0]   waddr_i,
  input  logic [CELL_W-1:0]   sig_raddr_i,
  input  logic [CELL_W-1:0]   sgn_raddr_i,
  input  logic [31:0]         sig_wdata_i,
  input  logic [31:0]         lap_wdata_i,
  input  logic                sgn_wdata_i,
  output logic [31:0]         sig_rdata_o,
  output logic [31:0]         lap_rdata_o,
  output logic                sgn_rdata_o
);

  logic [31:0] sig_mem [CELLS];
  logic [31:0] lap_mem [CELLS];
  logic        sgn_mem [CELLS];

  always_ff @(posedge clk_i) begin
    if (wen_i.sig_we) begin
      sig_mem[waddr_i] <= sig_wdata_i;
    end
    sig_rdata_o <= sig_mem[sig_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wen_i.lap_we) begin
      lap_mem[waddr_i] <= lap_wdata_i;
    end
    lap_rdata_o <= lap_mem[sig_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wen_i.sgn_we) begin
      sgn_mem[waddr_i] <= sgn_wdata_i;
    end
    sgn_rdata_o <= sgn_mem[sgn_raddr_i];
  end

endmodule

// ----- rtl/rsld_seq.sv -----
`timescale 1ns / 1ps
// Sequencer and datapath: clear, sign draw, load, read, Laplacian, update and energy passes.
module rsld_seq #(
  parameter int unsigned NODES = rsld_pkg::NodesDefault,
  parameter int unsigned DIM   = rsld_pkg::DimDefault,
  localparam int unsigned CELLS  = NODES * DIM,
  localparam int unsigned CELL_W = $clog2(CELLS),
  localparam int unsigned NODE_W = $clog2(NODES),
  localparam int unsigned DIM_W  = (DIM > 1) ? $clog2(DIM) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [63:0]         seed_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rsld_pkg::rsld_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsld_pkg::rsld_rsp_t out_rsp_o,
  output rsld_pkg::rsld_wen_t wen_o,
  output logic [CELL_W-1:0]   waddr_o,
  output logic [CELL_W-1:0]   sig_raddr_o,
  output logic [CELL_W-1:0]   sgn_raddr_o,
  output logic [31:0]         sig_wdata_o,
  output logic [31:0]         lap_wdata_o,
  output logic                sgn_wdata_o,
  input  logic [31:0]         sig_rdata_i,
  input  logic [31:0]         lap_rdata_i,
  input  logic                sgn_rdata_i
);

  localparam logic [2:0] SClr  = 3'd0;
  localparam logic [2:0] SIdle = 3'd1;
  localparam logic [2:0] SInit = 3'd2;
  localparam logic [2:0] SLoad = 3'd3;
  localparam logic [2:0] SRead = 3'd4;
  localparam logic [2:0] SLap  = 3'd5;
  localparam logic [2:0] SUpd  = 3'd6;
  localparam logic [2:0] SFin  = 3'd7;

  localparam logic [CELL_W-1:0] LastCell = CELL_W'(CELLS - 1);
  localparam logic [CELL_W-1:0] RowStep  = CELL_W'(DIM);
  localparam logic [CELL_W-1:0] WrapStep = CELL_W'((NODES - 1) * DIM);
  localparam logic [NODE_W-1:0] LastNode = NODE_W'(NODES - 1);
  localparam logic [DIM_W-1:0]  LastDim  = DIM_W'(DIM - 1);

  logic [2:0]          state_q;
  logic [1:0]          ph_q;
  logic [CELL_W-1:0]   idx_q;
  logic [NODE_W-1:0]   node_q;
  logic [DIM_W-1:0]    dim_q;
  rsld_pkg::rsld_req_t req_q;
  logic [63:0]         r_q;
  logic                store_q;
  logic                step_q;
  logic [31:0]         xp_q;
  logic [31:0]         xn_q;
  logic                sp_q;
  logic                sn_q;
  logic [62:0]         acc_q;
  logic [62:0]         last_energy_q;
  logic                energy_valid_q;
  logic [31:0]         viol_q;
  logic [31:0]         steps_q;
  logic                init_q;
  logic [31:0]         rd_q;
  logic                out_valid_q;
  rsld_pkg::rsld_rsp_t out_rsp_q;

  logic [CELL_W-1:0] idx_nx;
  logic [NODE_W-1:0] node_nx;
  logic [DIM_W-1:0]  dim_nx;
  logic              last_cell;
  logic [CELL_W-1:0] prev_addr;
  logic [CELL_W-1:0] next_addr;
  logic              ld_in_range;
  logic [CELL_W-1:0] ld_addr;
  logic [63:0]       r1;
  logic [63:0]       r2;
  logic [31:0]       tn;
  logic [31:0]       tp;
  logic [31:0]       lap_y;
  logic [31:0]       lap_abs;
  logic [62:0]       acc_d;
  logic [31:0]       upd_bias;
  logic [31:0]       upd_q;

  assign last_cell = (idx_q == LastCell);
  assign idx_nx    = last_cell ? '0 : idx_q + 1'b1;
  assign dim_nx    = (last_cell || dim_q == LastDim) ? '0 : dim_q + 1'b1;
  assign node_nx   = last_cell ? '0 : ((dim_q == LastDim) ? node_q + 1'b1 : node_q);
  assign prev_addr = (node_q == '0) ? idx_q + WrapStep : idx_q - RowStep;
  assign next_addr = (node_q == LastNode) ? idx_q - WrapStep : idx_q + RowStep;

  assign ld_in_range = (int'(req_q.node) < int'(NODES)) && (int'(req_q.dim) < int'(DIM));
  assign ld_addr     = CELL_W'(int'(req_q.node) * int'(DIM) + int'(req_q.dim));

  assign r1 = rsld_pkg::xorshift(r_q);
  assign r2 = rsld_pkg::xorshift(r1);

  assign tn      = sn_q ? xn_q : 32'd0 - xn_q;
  assign tp      = sp_q ? xp_q : 32'd0 - xp_q;
  assign lap_y   = {sig_rdata_i[30:0], 1'b0} - tn - tp;
  assign lap_abs = lap_y[31] ? 32'd0 - lap_y : lap_y;
  assign acc_d   = acc_q + {31'd0, lap_abs};

  assign upd_bias = lap_rdata_i + (lap_rdata_i[31] ? 32'd7 : 32'd0);
  assign upd_q    = {{3{upd_bias[31]}}, upd_bias[31:3]};

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_comb begin
    wen_o       = '0;
    waddr_o     = idx_q;
    sig_raddr_o = idx_q;
    sgn_raddr_o = idx_q;
    sig_wdata_o = '0;
    lap_wdata_o = lap_y;
    sgn_wdata_o = r1[0] ~^ r2[0];
    unique case (state_q)
      SClr: begin
        wen_o.sig_we = 1'b1;
      end
      SInit: begin
        wen_o.sig_we = 1'b1;
        wen_o.sgn_we = 1'b1;
      end
      SLoad: begin
        waddr_o      = ld_addr;
        wen_o.sig_we = ld_in_range;
        sig_wdata_o  = req_q.value;
      end
      SRead: begin
        sig_raddr_o = ld_addr;
      end
      SLap: begin
        unique case (ph_q)
          2'd0: begin
            sig_raddr_o = prev_addr;
            sgn_raddr_o = prev_addr;
          end
          2'd1: begin
            sig_raddr_o = next_addr;
          end
          2'd2: begin
            sig_raddr_o = idx_q;
          end
          default: begin
            wen_o.lap_we = store_q;
          end
        endcase
      end
      SUpd: begin
        wen_o.sig_we = ph_q[0];
        sig_wdata_o  = sig_rdata_i - upd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SClr;
      ph_q           <= '0;
      idx_q          <= '0;
      node_q         <= '0;
      dim_q          <= '0;
      store_q        <= 1'b0;
      step_q         <= 1'b0;
      energy_valid_q <= 1'b0;
      viol_q         <= '0;
      steps_q        <= '0;
      init_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != SFin) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SClr: begin
          idx_q  <= idx_nx;
          node_q <= node_nx;
          dim_q  <= dim_nx;
          if (last_cell) begin
            state_q <= SIdle;
          end
        end
        SIdle: begin
          if (in_valid_i) begin
            req_q   <= in_req_i;
            rd_q    <= '0;
            acc_q   <= '0;
            ph_q    <= '0;
            store_q <= (in_req_i.mode == rsld_pkg::ModeStep);
            step_q  <= (in_req_i.mode == rsld_pkg::ModeStep);
            unique case (in_req_i.mode)
              rsld_pkg::ModeInit: begin
                r_q     <= (seed_i != '0) ? seed_i : rsld_pkg::DefaultSeed;
                state_q <= SInit;
              end
              rsld_pkg::ModeLoad: state_q <= SLoad;
              rsld_pkg::ModeStep: state_q <= SLap;
              default:            state_q <= SRead;
            endcase
          end
        end
        SInit: begin
          r_q    <= r2;
          idx_q  <= idx_nx;
          node_q <= node_nx;
          dim_q  <= dim_nx;
          if (last_cell) begin
            energy_valid_q <= 1'b0;
            viol_q         <= '0;
            steps_q        <= '0;
            init_q         <= 1'b1;
            state_q        <= SFin;
          end
        end
        SLoad: begin
          state_q <= req_q.last ? SLap : SFin;
        end
        SRead: begin
          if (ph_q == 2'd0) begin
            ph_q <= 2'd1;
          end else begin
            ph_q    <= '0;
            rd_q    <= ld_in_range ? sig_rdata_i : '0;
            state_q <= SFin;
          end
        end
        SLap: begin
          ph_q <= ph_q + 1'b1;
          unique case (ph_q)
            2'd1: begin
              xp_q <= sig_rdata_i;
              sp_q <= sgn_rdata_i;
            end
            2'd2: begin
              xn_q <= sig_rdata_i;
              sn_q <= sgn_rdata_i;
            end
            2'd3: begin
              acc_q  <= acc_d;
              idx_q  <= idx_nx;
              node_q <= node_nx;
              dim_q  <= dim_nx;
              if (last_cell) begin
                if (store_q) begin
                  state_q <= SUpd;
                end else begin
                  if (step_q) begin
                    if (energy_valid_q && acc_d > last_energy_q) begin
                      viol_q <= viol_q + 1'b1;
                    end
                    steps_q <= steps_q + 1'b1;
                  end
                  last_energy_q  <= acc_d;
                  energy_valid_q <= 1'b1;
                  state_q        <= SFin;
                end
              end
            end
            default: begin
            end
          endcase
        end
        SUpd: begin
          ph_q <= {1'b0, ~ph_q[0]};
          if (ph_q[0]) begin
            idx_q  <= idx_nx;
            node_q <= node_nx;
            dim_q  <= dim_nx;
            if (last_cell) begin
              store_q <= 1'b0;
              acc_q   <= '0;
              state_q <= SLap;
            end
          end
        end
        default: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q          <= 1'b1;
            out_rsp_q.value_out  <= rd_q;
            out_rsp_q.energy     <= energy_valid_q ? last_energy_q : '0;
            out_rsp_q.violations <= viol_q;
            out_rsp_q.steps      <= steps_q;
            out_rsp_q.ok         <= init_q && (viol_q == '0);
            state_q              <= SIdle;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/ring_sheaf_laplacian_diffusion_core.sv -----
`timescale 1ns / 1ps
// Top level of the ring sheaf Laplacian diffusion core: seed register, sequencer and memories.
//
//   channel  direction  handshake            payload
//   in       request in valid / stall_o      rsld_req_t
//   out      result out valid / stall_i      rsld_rsp_t
//   cfg      write in   valid / ready        64-bit seed
//
// The single read port of the signal memory makes the Laplacian pass read each
// cell's two neighbours and then the cell itself in turn, and the update pass read
// each cell before writing it back. After reset a clearing pass zeroes the signal;
// no request is taken meanwhile. A finished result waits in the output register
// under stall.
module ring_sheaf_laplacian_diffusion_core #(
  parameter int unsigned NODES = rsld_pkg::NodesDefault,
  parameter int unsigned DIM   = rsld_pkg::DimDefault,
  localparam int unsigned CELL_W = $clog2(NODES * DIM)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rsld_pkg::rsld_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsld_pkg::rsld_rsp_t out_rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [63:0]         cfg_data_i
);

  logic [63:0]         seed_q;
  rsld_pkg::rsld_wen_t wen;
  logic [CELL_W-1:0]   waddr;
  logic [CELL_W-1:0]   sig_raddr;
  logic [CELL_W-1:0]   sgn_raddr;
  logic [31:0]         sig_wdata;
  logic [31:0]         lap_wdata;
  logic                sgn_wdata;
  logic [31:0]         sig_rdata;
  logic [31:0]         lap_rdata;
  logic                sgn_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seed_q <= cfg_data_i;
    end
  end

  rsld_seq #(
    .NODES (NODES),
    .DIM   (DIM)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .wen_o       (wen),
    .waddr_o     (waddr),
    .sig_raddr_o (sig_raddr),
    .sgn_raddr_o (sgn_raddr),
    .sig_wdata_o (sig_wdata),
    .lap_wdata_o (lap_wdata),
    .sgn_wdata_o (sgn_wdata),
    .sig_rdata_i (sig_rdata),
    .lap_rdata_i (lap_rdata),
    .sgn_rdata_i (sgn_rdata)
  );

  rsld_store #(
    .NODES (NODES),
    .DIM   (DIM)
  ) u_store (
    .clk_i       (clk_i),
    .wen_i       (wen),
    .waddr_i     (waddr),
    .sig_raddr_i (sig_raddr),
    .sgn_raddr_i (sgn_raddr),
    .sig_wdata_i (sig_wdata),
    .lap_wdata_i (lap_wdata),
    .sgn_wdata_i (sgn_wdata),
    .sig_rdata_o (sig_rdata),
    .lap_rdata_o (lap_rdata),
    .sgn_rdata_o (sgn_rdata)
  );

endmodule

// ----- rtl/rsld_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the ring sheaf diffusion core and their bind.
module rsld_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input rsld_pkg::rsld_req_t in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rsld_pkg::rsld_rsp_t out_rsp_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [63:0]         cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result dropped or changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one still in work");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

  a_ok_no_violation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.ok |-> out_rsp_o.violations == '0)
    else $error("ok set with violations");

endmodule

bind ring_sheaf_laplacian_diffusion_core rsld_checker u_rsld_checker (.*);

// ----- tb/tb_ring_sheaf_laplacian_diffusion_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the ring sheaf Laplacian diffusion core with a predicting scoreboard.
module tb_ring_sheaf_laplacian_diffusion_core;

  localparam int unsigned Cells = rsld_pkg::NodesDefault * rsld_pkg::DimDefault;

  class diffusion_scoreboard;
    bit [63:0] seed_reg;
    bit [31:0] sig [Cells];
    bit        pos_u [Cells];
    bit        pos_v [Cells];
    bit [31:0] lap [Cells];
    bit [63:0] energy_q;
    bit        energy_ok;
    bit [31:0] rises;
    bit [31:0] step_cnt;
    bit        inited;
    rsld_pkg::rsld_rsp_t pending [$];
    int        mismatches;
    int        n_init, n_load, n_step, n_read, n_checked;

    function void reset_state();
      seed_reg = '0;
      foreach (sig[i]) begin
        sig[i] = '0;
        pos_u[i] = 1'b0;
        pos_v[i] = 1'b0;
      end
      energy_q = '0;
      energy_ok = 1'b0;
      rises = '0;
      step_cnt = '0;
      inited = 1'b0;
    endfunction

    function void build_laplacian();
      int unsigned u, v, k;
      bit [31:0] xu, xv, eps;
      foreach (lap[i]) lap[i] = '0;
      for (int e = 0; e < rsld_pkg::NodesDefault; e++) begin
        u = e;
        v = (e + 1) % rsld_pkg::NodesDefault;
        for (int d = 0; d < rsld_pkg::DimDefault; d++) begin
          k = e * rsld_pkg::DimDefault + d;
          xu = pos_u[k] ? sig[u*rsld_pkg::DimDefault+d] : -sig[u*rsld_pkg::DimDefault+d];
          xv = pos_v[k] ? sig[v*rsld_pkg::DimDefault+d] : -sig[v*rsld_pkg::DimDefault+d];
          eps = xu - xv;
          lap[u*rsld_pkg::DimDefault+d] += pos_u[k] ? eps : -eps;
          lap[v*rsld_pkg::DimDefault+d] += pos_v[k] ? -eps : eps;
        end
      end
    endfunction

    function bit [63:0] l1_energy();
      bit [63:0] sum;
      sum = '0;
      build_laplacian();
      foreach (lap[i]) sum += lap[i][31] ? {32'd0, -lap[i]} : {32'd0, lap[i]};
      return sum;
    endfunction

    function bit [63:0] shuffle(bit [63:0] r);
      r ^= r << 13;
      r ^= r >> 7;
      r ^= r << 17;
      return r;
    endfunction

    function void note_request(rsld_pkg::rsld_req_t req);
      rsld_pkg::rsld_rsp_t rsp;
      bit [63:0] r, fresh;
      int        q;
      int unsigned idx;
      rsp = '0;
      idx = req.node * rsld_pkg::DimDefault + req.dim;
      case (req.mode)
        rsld_pkg::ModeInit: begin
          n_init++;
          r = (seed_reg != 0) ? seed_reg : rsld_pkg::DefaultSeed;
          for (int k = 0; k < Cells; k++) begin
            r = shuffle(r);
            pos_u[k] = r[0];
            r = shuffle(r);
            pos_v[k] = r[0];
            sig[k] = '0;
          end
          energy_q = '0;
          energy_ok = 1'b0;
          rises = '0;
          step_cnt = '0;
          inited = 1'b1;
        end
        rsld_pkg::ModeLoad: begin
          n_load++;
          sig[idx] = req.value;
          if (req.last) begin
            energy_q = l1_energy();
            energy_ok = 1'b1;
          end
        end
        rsld_pkg::ModeStep: begin
          n_step++;
          build_laplacian();
          foreach (sig[i]) begin
            q = $signed(lap[i]) / 8;
            sig[i] -= q;
          end
          fresh = l1_energy();
          if (energy_ok && fresh > energy_q) rises++;
          energy_q = fresh;
          energy_ok = 1'b1;
          step_cnt++;
        end
        default: begin
          n_read++;
          rsp.value_out = sig[idx];
        end
      endcase
      rsp.energy = energy_ok ? energy_q[62:0] : '0;
      rsp.violations = rises;
      rsp.steps = step_cnt;
      rsp.ok = inited && (rises == 0);
      pending.push_back(rsp);
    endfunction

    function void check_result(rsld_pkg::rsld_rsp_t got);
      rsld_pkg::rsld_rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with none expected: %p", got);
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got.value_out !== want.value_out || got.energy !== want.energy ||
          got.violations !== want.violations || got.steps !== want.steps ||
          got.ok !== want.ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d expected %p got %p", n_checked, want, got);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  rsld_pkg::rsld_req_t in_req_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  rsld_pkg::rsld_rsp_t out_rsp_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [63:0] cfg_data_i = '0;

  diffusion_scoreboard sb = new();
  bit quiet = 1'b0;
  int stall_left = 0;

  always #4 clk_i = ~clk_i;

  ring_sheaf_laplacian_diffusion_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
    if (stall_left > 0) begin
      stall_left--;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
    end
  end

  task automatic send(input rsld_pkg::rsld_req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req_i <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  task automatic issue(input logic [1:0] mode, input int node, input int dim,
                       input logic [31:0] value, input bit last);
    rsld_pkg::rsld_req_t req;
    req.mode = mode;
    req.node = 4'(node);
    req.dim = 3'(dim);
    req.value = value;
    req.last = last;
    send(req);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [63:0] s);
    cfg_data_i <= s;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.seed_reg = s;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return {{20{$urandom_range(0, 1) == 1}}, 12'($urandom())};
      default: return $signed(32'($urandom_range(0, 8191))) - 4096;
    endcase
  endfunction

  task automatic random_run(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) issue(rsld_pkg::ModeInit, 0, 0, $urandom(), 1'($urandom_range(0, 1)));
      else if (r < 52) issue(rsld_pkg::ModeLoad, $urandom_range(0, 15), $urandom_range(0, 7),
                             pick_value(), 1'b0);
      else if (r < 62) issue(rsld_pkg::ModeLoad, $urandom_range(0, 15), $urandom_range(0, 7),
                             pick_value(), 1'b1);
      else if (r < 70) issue(rsld_pkg::ModeStep, $urandom_range(0, 15), $urandom_range(0, 7),
                             $urandom(), 1'($urandom_range(0, 1)));
      else issue(rsld_pkg::ModeRead, $urandom_range(0, 15), $urandom_range(0, 7),
                 $urandom(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [63:0] seeds [5];
    seeds[0] = 64'd0;
    seeds[1] = '1;
    seeds[2] = 64'd1;
    seeds[3] = 64'h8000_0000_0000_0000;
    seeds[4] = {$urandom(), $urandom()};
    sb.reset_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_seed(seeds[0]);

    issue(rsld_pkg::ModeInit, 15, 7, 32'hFFFF_FFFF, 1'b1);
    issue(rsld_pkg::ModeRead, 0, 0, 32'h0, 1'b0);
    issue(rsld_pkg::ModeStep, 0, 0, 32'h0, 1'b0);
    issue(rsld_pkg::ModeLoad, 0, 0, 32'h7FFF_FFFF, 1'b0);
    issue(rsld_pkg::ModeLoad, 15, 7, 32'h8000_0000, 1'b0);
    issue(rsld_pkg::ModeLoad, 1, 0, 32'h8000_0000, 1'b0);
    issue(rsld_pkg::ModeLoad, 7, 3, 32'hFFFF_FFFF, 1'b1);
    issue(rsld_pkg::ModeRead, 0, 0, 32'h0, 1'b1);
    issue(rsld_pkg::ModeRead, 15, 7, 32'hFFFF_FFFF, 1'b0);
    issue(rsld_pkg::ModeRead, 1, 0, 32'h0, 1'b0);
    issue(rsld_pkg::ModeStep, 15, 7, 32'hFFFF_FFFF, 1'b1);
    issue(rsld_pkg::ModeStep, 0, 0, 32'h0, 1'b0);
    issue(rsld_pkg::ModeRead, 7, 3, 32'h0, 1'b0);
    issue(rsld_pkg::ModeLoad, 2, 5, 32'h0001_0000, 1'b1);
    issue(rsld_pkg::ModeStep, 0, 0, 32'h0, 1'b0);
    issue(rsld_pkg::ModeRead, 2, 5, 32'h0, 1'b0);
    issue(rsld_pkg::ModeInit, 0, 0, 32'h0, 1'b0);
    issue(rsld_pkg::ModeRead, 15, 7, 32'h0, 1'b0);
    drain();

    for (int p = 0; p < 5; p++) begin
      quiet = (p == 2);
      if (p > 0) write_seed(seeds[p]);
      issue(rsld_pkg::ModeInit, 0, 0, 32'h0, 1'b0);
      random_run(215);
      drain();
    end
    quiet = 1'b0;

    $display("Covered %0d inits, %0d loads, %0d steps, %0d reads over five seeds",
             sb.n_init, sb.n_load, sb.n_step, sb.n_read);
    $display("Checked %0d results, %0d mismatches", sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("** ring_sheaf_laplacian_diffusion_core: PASSED **");
    end else begin
      $display("** ring_sheaf_laplacian_diffusion_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timeout with %0d results outstanding", sb.pending.size());
    $display("** ring_sheaf_laplacian_diffusion_core: FAILED **");
    $finish;
  end

endmodule
